### design/fca_pkg.sv
// Shared types and constants for the frame clock accounting block.
// No dependencies; imported by fca_div and frame_clock_accounting.
`default_nettype none

package fca_pkg;

  localparam int unsigned TimerW      = 16;
  localparam int unsigned TickW       = 64;
  localparam int unsigned CountW      = 32;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned MinFrameTicks = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMeasuredFrameTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] RegClockOrigin        = 2'd1;

  // Event command codes
  localparam logic CmdObserve    = 1'b0;
  localparam logic CmdFrameEdge  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [TimerW-1:0] timer_value;
  } fca_in_t;

  typedef struct packed {
    logic [TickW-1:0]  tick_total;
    logic [CountW-1:0] frames_added;
    logic [CountW-1:0] program_frames;
    logic [CountW-1:0] shown_frames;
  } fca_out_t;

endpackage

`default_nettype wire

### design/fca_div.sv
// Bit-serial restoring divider: 64-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on fca_pkg for widths.
`default_nettype none

module fca_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fca_pkg::TickW-1:0]    dividend_i,
  input  logic [fca_pkg::TimerW-1:0]   divisor_i,
  output logic                         done_o,
  output logic [fca_pkg::CountW-1:0]   quotient_o
);
  import fca_pkg::*;

  localparam int unsigned CntW = $clog2(TickW);

  logic [TickW-1:0]  dvd_q, dvd_d;
  logic [TimerW-1:0] div_q, div_d;
  logic [TimerW-1:0] rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [TimerW:0]   rem_sh;
  logic [TimerW:0]   rem_sub;
  logic              q_bit;

  // Bring in the next dividend bit and trial-subtract the divisor
  assign rem_sh  = {rem_q, dvd_q[TickW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign q_bit   = (rem_sh >= {1'b0, div_q});

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits enter at the bottom as dividend bits leave the top
      dvd_d = {dvd_q[TickW-2:0], q_bit};
      rem_d = q_bit ? rem_sub[TimerW-1:0] : rem_sh[TimerW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q[CountW-1:0];

endmodule

`default_nettype wire

### design/frame_clock_accounting.sv
// Top level of the frame clock accounting block: tick total, frame counters, control.
// Depends on fca_pkg and fca_div.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------
//   in      | input     | in_valid_i/in_stall_o   | fca_in_t
//   out     | output    | out_valid_o/out_stall_i | fca_out_t
//   cfg     | input     | cfg_we_i             | cfg_index_i, cfg_data_i
//
// An observe or an uncalibrated frame edge passes StAbsorb and StFinish to the output register.
// A calibrated frame edge also passes StDelta, StRound and StDivide (bit-serial divider, 64 steps).
// One event is in flight at a time; the next is taken while a result waits in the
// output register. A stalled output holds the finished event in its last state.
// Reset and any write to a mapped config register clear all counters and reload the last sample.
`default_nettype none

module frame_clock_accounting (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fca_pkg::fca_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fca_pkg::fca_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [fca_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fca_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fca_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StAbsorb,
    StDelta,
    StRound,
    StDivide,
    StFinish
  } state_e;

  state_e            state_q;
  logic [TimerW-1:0] meas_q;
  logic [TimerW-1:0] origin_q;
  logic [TimerW-1:0] last_timer_q;
  logic [TickW-1:0]  tick_total_q;
  logic [TickW-1:0]  last_frame_q;
  logic [CountW-1:0] prog_cnt_q;
  logic [CountW-1:0] disp_cnt_q;
  logic [CountW-1:0] added_q;
  logic [TickW-1:0]  work_q;
  fca_in_t           item_q;
  logic              out_valid_q;
  fca_out_t          out_q;

  logic              calibrated;
  logic [TimerW-1:0] tpf;
  logic [TimerW-1:0] diff;
  logic              div_start;
  logic [TickW-1:0]  div_dividend;
  logic              div_done;
  logic [CountW-1:0] div_quot;
  logic [CountW-1:0] div_added;
  logic              slot_free;
  logic              out_load;
  logic              in_fire;

  assign calibrated   = (meas_q >= TimerW'(MinFrameTicks));
  assign tpf          = calibrated ? meas_q : '0;
  assign diff         = item_q.timer_value - last_timer_q;
  assign div_start    = (state_q == StRound);
  assign div_dividend = work_q + TickW'(tpf >> 1);
  assign div_added    = (div_quot == '0) ? CountW'(1) : div_quot;
  assign slot_free    = !out_valid_q || !out_stall_i;
  assign out_load     = (state_q == StFinish) && slot_free;
  assign in_fire      = in_valid_i && !in_stall_o;

  fca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (tpf),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      meas_q       <= '0;
      origin_q     <= '0;
      last_timer_q <= '0;
      tick_total_q <= '0;
      last_frame_q <= '0;
      prog_cnt_q   <= '0;
      disp_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_index_i == RegMeasuredFrameTicks ||
                       cfg_index_i == RegClockOrigin)) begin
        // restart all counters; origin reload uses the incoming value when it changes
        if (cfg_index_i == RegMeasuredFrameTicks) begin
          meas_q       <= cfg_data_i;
          last_timer_q <= origin_q;
        end else begin
          origin_q     <= cfg_data_i;
          last_timer_q <= cfg_data_i;
        end
        tick_total_q <= '0;
        last_frame_q <= '0;
        prog_cnt_q   <= '0;
        disp_cnt_q   <= '0;
      end else begin
        case (state_q)
          StIdle: begin
            if (in_fire) begin
              state_q <= StAbsorb;
            end
          end
          StAbsorb: begin
            if (calibrated) begin
              last_timer_q <= item_q.timer_value;
              tick_total_q <= tick_total_q + TickW'(diff);
            end
            if (item_q.cmd == CmdFrameEdge) begin
              prog_cnt_q <= prog_cnt_q + CountW'(1);
              if (calibrated) begin
                state_q <= StDelta;
              end else begin
                disp_cnt_q <= disp_cnt_q + CountW'(1);
                state_q    <= StFinish;
              end
            end else begin
              state_q <= StFinish;
            end
          end
          StDelta: begin
            state_q <= StRound;
          end
          StRound: begin
            state_q <= StDivide;
          end
          StDivide: begin
            if (div_done) begin
              disp_cnt_q   <= disp_cnt_q + div_added;
              last_frame_q <= tick_total_q;
              state_q      <= StFinish;
            end
          end
          StFinish: begin
            if (slot_free) begin
              state_q <= StIdle;
            end
          end
          default: begin
            state_q <= StIdle;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (state_q == StAbsorb) begin
      added_q <= (item_q.cmd == CmdFrameEdge) ? CountW'(1) : '0;
    end
    if (state_q == StDelta) begin
      work_q <= tick_total_q - last_frame_q;
    end
    if (state_q == StDivide && div_done) begin
      added_q <= div_added;
    end
    if (out_load) begin
      out_q.tick_total     <= calibrated ? tick_total_q : '0;
      out_q.frames_added   <= added_q;
      out_q.program_frames <= prog_cnt_q;
      out_q.shown_frames   <= disp_cnt_q;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### bench/frame_clock_accounting_tb.sv
// Self-checking bench for frame_clock_accounting: a directed table, then random phases.
// Expected reports come from a cycle-free model of the tick and frame accounting.
// Depends on fca_pkg and the frame_clock_accounting RTL only.
module frame_clock_accounting_tb;
  import fca_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnmapped2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnmapped3 = 2'd3;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned TailCycles   = 100;
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned PhaseEvents  = 130;
  localparam int unsigned NumDirRows   = 24;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    fca_in_t             ev;
    logic                typed;
    fca_out_t            want;
  } dir_row_t;

  logic clk_i;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fca_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fca_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Model state
  logic [TimerW-1:0]   tpf_reg, origin_reg, prev_sample;
  logic [TickW-1:0]    tick_sum, edge_mark;
  logic [CountW-1:0]   prog_frames, disp_frames;

  fca_out_t    frame_reports_due [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_events = 0, n_edges = 0, n_writes = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;

  frame_clock_accounting dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void restart_counters();
    prev_sample = origin_reg;
    tick_sum    = '0;
    edge_mark   = '0;
    prog_frames = '0;
    disp_frames = '0;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    if (idx == RegMeasuredFrameTicks) begin
      tpf_reg = data;
    end else if (idx == RegClockOrigin) begin
      origin_reg = data;
    end else begin
      return;
    end
    restart_counters();
  endfunction

  function automatic fca_out_t account_event(fca_in_t ev);
    logic [TimerW-1:0] eff;
    logic [TimerW-1:0] diff;
    logic [TickW-1:0]  rounded;
    logic [TickW-1:0]  quot;
    logic [CountW-1:0] added;
    fca_out_t          rep;
    eff   = (tpf_reg >= MinFrameTicks) ? tpf_reg : '0;
    added = '0;
    if (eff != 0) begin
      diff        = ev.timer_value - prev_sample;
      tick_sum    = tick_sum + {48'd0, diff};
      prev_sample = ev.timer_value;
    end
    if (ev.cmd == CmdFrameEdge) begin
      prog_frames = prog_frames + 1;
      if (eff == 0) begin
        added = 1;
      end else begin
        // round to nearest; the sum wraps at 64 bits
        rounded   = (tick_sum - edge_mark) + {48'd0, eff >> 1};
        edge_mark = tick_sum;
        quot      = rounded / {48'd0, eff};
        added     = quot[CountW-1:0];
        if (added == 0) added = 1;
      end
      disp_frames = disp_frames + added;
    end
    rep.tick_total     = (eff != 0) ? tick_sum : '0;
    rep.frames_added   = added;
    rep.program_frames = prog_frames;
    rep.shown_frames   = disp_frames;
    return rep;
  endfunction

  // Offer one event after a random gap; record its report once the transfer happens.
  task automatic send_event(input fca_in_t ev, input logic typed, input fca_out_t want);
    int unsigned gap;
    fca_out_t    rep;
    gap = quiet ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = ev;
    do @(posedge clk_i); while (in_stall);
    rep = account_event(ev);
    frame_reports_due.push_back(typed ? want : rep);
    n_events++;
    if (ev.cmd == CmdFrameEdge) n_edges++;
  endtask

  task automatic wait_for_reports();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (frame_reports_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_for_reports();
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    apply_reg(idx, data);
    n_writes++;
  endtask

  task automatic check_report(input fca_out_t got);
    fca_out_t want;
    if (frame_reports_due.size() == 0) begin
      $error("report with nothing outstanding: tick_total %0d", got.tick_total);
      err_cnt++;
      return;
    end
    want = frame_reports_due.pop_front();
    if (got.tick_total !== want.tick_total) begin
      $error("tick_total: expected %0d, got %0d", want.tick_total, got.tick_total);
      err_cnt++;
    end
    if (got.frames_added !== want.frames_added) begin
      $error("frames_added: expected %0d, got %0d", want.frames_added, got.frames_added);
      err_cnt++;
    end
    if (got.program_frames !== want.program_frames) begin
      $error("program_frames: expected %0d, got %0d", want.program_frames, got.program_frames);
      err_cnt++;
    end
    if (got.shown_frames !== want.shown_frames) begin
      $error("shown_frames: expected %0d, got %0d", want.shown_frames, got.shown_frames);
      err_cnt++;
    end
  endtask

  // Report sink: random stall before each transfer, one long hold-off on request.
  initial begin : report_sink
    int unsigned gap;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        @(negedge clk_i);
        out_stall = 1'b1;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall = 1'b0;
      do @(posedge clk_i); while (!out_valid);
      check_report(out_data);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  dir_row_t dir_rows [NumDirRows] = '{
    // uncalibrated after reset: no ticks, one display frame per edge
    '{1'b0, RegMeasuredFrameTicks, 16'd0, '{CmdObserve,   16'hFFFF}, 1'b1,
      '{64'd0, 32'd0, 32'd0, 32'd0}},
    '{1'b0, RegMeasuredFrameTicks, 16'd0, '{CmdFrameEdge, 16'h1234}, 1'b1,
      '{64'd0, 32'd1, 32'd1, 32'd1}},
    '{1'b0, RegMeasuredFrameTicks, 16'd0, '{CmdFrameEdge, 16'h0000}, 1'b1,
      '{64'd0, 32'd1, 32'd2, 32'd2}},
    '{1'b1, RegMeasuredFrameTicks, 16'd63, '{CmdObserve,  16'h0000}, 1'b0, '0},
    '{1'b0, RegMeasuredFrameTicks, 16'd0, '{CmdFrameEdge, 16'hFFFF}, 1'b1,
      '{64'd0, 32'd1, 32'd1, 32'd1}},
    // writes past the register list leave the counters alone
    '{1'b1, RegUnmapped2, 16'hFFFF, '{CmdObserve,   16'h0000}, 1'b0, '0},
    '{1'b0, RegUnmapped2, 16'd0,    '{CmdFrameEdge, 16'h5555}, 1'b1,
      '{64'd0, 32'd1, 32'd2, 32'd2}},
    '{1'b1, RegUnmapped3, 16'd0,    '{CmdObserve,   16'h0000}, 1'b0, '0},
    '{1'b0, RegUnmapped3, 16'd0,    '{CmdObserve,   16'hAAAA}, 1'b1,
      '{64'd0, 32'd0, 32'd2, 32'd2}},
    '{1'b1, RegClockOrigin,        16'hFFF0, '{CmdObserve, 16'h0000}, 1'b0, '0},
    '{1'b1, RegMeasuredFrameTicks, 16'd64,   '{CmdObserve, 16'h0000}, 1'b0, '0},
    // smallest calibrated period, wrap from the origin, zero quotient
    '{1'b0, RegClockOrigin, 16'd0, '{CmdObserve,   16'h0010}, 1'b1,
      '{64'd32, 32'd0, 32'd0, 32'd0}},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdFrameEdge, 16'h0010}, 1'b1,
      '{64'd32, 32'd1, 32'd1, 32'd1}},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdFrameEdge, 16'h002F}, 1'b1,
      '{64'd63, 32'd1, 32'd2, 32'd2}},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdFrameEdge, 16'h0010}, 1'b1,
      '{64'd65568, 32'd1024, 32'd3, 32'd1026}},
    '{1'b1, RegMeasuredFrameTicks, 16'hFFFF, '{CmdObserve, 16'h0000}, 1'b0, '0},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdObserve,   16'h0000}, 1'b1,
      '{64'd16, 32'd0, 32'd0, 32'd0}},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdFrameEdge, 16'hFFFF}, 1'b1,
      '{64'd65551, 32'd1, 32'd1, 32'd1}},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdObserve,   16'h8000}, 1'b0, '0},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdFrameEdge, 16'h7FFF}, 1'b0, '0},
    '{1'b1, RegClockOrigin,        16'd0, '{CmdObserve, 16'h0000}, 1'b0, '0},
    '{1'b1, RegMeasuredFrameTicks, 16'd0, '{CmdObserve, 16'h0000}, 1'b0, '0},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdFrameEdge, 16'hABCD}, 1'b1,
      '{64'd0, 32'd1, 32'd1, 32'd1}},
    '{1'b0, RegClockOrigin, 16'd0, '{CmdObserve,   16'h1357}, 1'b1,
      '{64'd0, 32'd0, 32'd1, 32'd1}}
  };

  initial begin : stimulus
    logic [TimerW-1:0] tpf, origin, timer;
    int unsigned       base, step;
    fca_in_t           ev;
    tpf_reg    = '0;
    origin_reg = '0;
    restart_counters();
    repeat (10) @(negedge clk_i);
    rst_n = 1'b1;

    for (int r = 0; r < NumDirRows; r++) begin
      if (dir_rows[r].is_cfg) begin
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_event(dir_rows[r].ev, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: tpf = 16'd64;
        1: tpf = 16'hFFFF;
        2: tpf = 16'd63;
        3: tpf = 16'd0;
        5: tpf = 16'd1000;
        6: tpf = 16'd100;
        7: tpf = 16'd16667;
        9: tpf = 16'd200;
        default: tpf = TimerW'($urandom_range(MinFrameTicks, 65535));
      endcase
      origin = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : TimerW'($urandom_range(0, 65535));
      write_reg(RegClockOrigin, origin);
      write_reg(RegMeasuredFrameTicks, tpf);
      quiet = (p == 3);
      // starve the sink so the block fills and stalls its input
      if (p == 5) hold_req = 1'b1;
      base  = (tpf >= MinFrameTicks) ? tpf : 1000;
      timer = origin;
      for (int n = 0; n < PhaseEvents; n++) begin
        if (p == 2 && n == PhaseEvents / 2) wait_for_reports();
        step = $urandom_range(0, 2 * base);
        // mostly a steadily advancing timer, now and then a jump anywhere
        if ($urandom_range(0, 7) == 0) timer = TimerW'($urandom);
        else timer = timer + step[TimerW-1:0];
        ev.cmd         = ($urandom_range(0, 2) == 0) ? CmdFrameEdge : CmdObserve;
        ev.timer_value = timer;
        send_event(ev, 1'b0, '0);
      end
      quiet = 1'b0;
    end

    wait_for_reports();
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d events (%0d frame edges) over %0d register writes,", n_events,
             n_edges, n_writes);
    $display("periods from uncalibrated to 65535 ticks, with a long sink hold-off");
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
